FILE: rtl/core/lpcd_pkg.sv
// Shared types and constants for the length-prefixed chunk deframer.
// Used by the parser, the result queue and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpcd_pkg;

    // header position counter width, holds up to length plus context bytes
    localparam int HPOS_W = 4;

    // result queue geometry
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // packed result width on the output stream
    localparam int OUT_DATA_W = 144;

    typedef enum logic [1:0] {
        PH_PREFIX  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_ERROR   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        KIND_PAYLOAD   = 2'd0,
        KIND_CHUNK_END = 2'd1,
        KIND_ACCEPT    = 2'd2,
        KIND_REJECT    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_TRUNC_HEADER = 2'd1,
        ERR_LEN_SHORT    = 2'd2,
        ERR_LEN_EXCEEDS  = 2'd3
    } err_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [31:0] chunk_index;
        logic [31:0] payload_length;
        logic [31:0] context_word;
        err_t        error_code;
        logic [31:0] chunk_count;
        logic        last;
    } result_t;

    // results produced by one input transaction
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } push_t;

endpackage : lpcd_pkg

`default_nettype wire

FILE: rtl/core/lpcd_parser.sv
// Chunk parser: header capture, payload counting and verdict generation.
// Depends on lpcd_pkg; produces up to two results per input byte.
`timescale 1ns / 1ps
`default_nettype none

module lpcd_parser #(
    parameter int LENGTH_BYTES  = 8,
    parameter int CONTEXT_BYTES = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_action,
    input  logic [7:0]      in_byte,
    output lpcd_pkg::push_t push
);
    import lpcd_pkg::*;

    localparam int                HDR_BYTES = LENGTH_BYTES + CONTEXT_BYTES;
    localparam int                LEN_W     = LENGTH_BYTES * 8;
    localparam logic [HPOS_W-1:0] HDR_LAST  = HPOS_W'(HDR_BYTES - 1);
    localparam logic [63:0]       CTX_LEN   = 64'(CONTEXT_BYTES);

    phase_t            phase_reg, phase_next;
    logic [HPOS_W-1:0] hpos_reg, hpos_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [31:0]       left_reg, left_next;
    logic [31:0]       plen_reg, plen_next;
    logic [31:0]       ctx_reg, ctx_next;
    logic [31:0]       done_reg, done_next;
    err_t              err_reg, err_next;

    logic [LEN_W-1:0]  len_cur;
    logic [31:0]       ctx_cur;
    logic [63:0]       len_full;
    logic [63:0]       diff;
    logic              short_len;
    logic              huge_len;
    logic              zero_len;
    logic              hdr_end;
    logic              body_end;
    logic              is_data;
    logic              is_end;
    err_t              verdict_err;

    assign is_data = in_valid && !in_action;
    assign is_end  = in_valid && in_action;

    // header bytes merged with the incoming byte
    always_comb
    begin
        len_cur = len_reg;
        for (int i = 0; i < LENGTH_BYTES; i++)
        begin
            if (hpos_reg == HPOS_W'(i))
            begin
                len_cur[8*i +: 8] = in_byte;
            end
        end
        ctx_cur = ctx_reg;
        for (int j = 0; j < CONTEXT_BYTES; j++)
        begin
            if (hpos_reg == HPOS_W'(LENGTH_BYTES + j))
            begin
                ctx_cur[8*j +: 8] = in_byte;
            end
        end
    end

    // length checks at the last header byte
    assign len_full  = 64'(len_cur);
    assign diff      = len_full - CTX_LEN;
    assign short_len = len_full < CTX_LEN;
    assign huge_len  = |diff[63:32];
    assign zero_len  = diff[31:0] == 32'd0;
    assign hdr_end   = hpos_reg == HDR_LAST;
    assign body_end  = left_reg == 32'd1;

    // verdict error: latched error first, then partial chunk
    always_comb
    begin
        verdict_err = err_reg;
        if (err_reg == ERR_NONE)
        begin
            if (phase_reg == PH_PAYLOAD)
            begin
                verdict_err = ERR_LEN_EXCEEDS;
            end
            else if (hpos_reg != '0)
            begin
                verdict_err = ERR_TRUNC_HEADER;
            end
        end
    end

    // phase next state
    always_comb
    begin
        phase_next = phase_reg;
        if (is_end)
        begin
            phase_next = PH_PREFIX;
        end
        else if (is_data)
        begin
            case (phase_reg)
                PH_PREFIX:
                begin
                    if (hdr_end)
                    begin
                        if (short_len || huge_len)
                        begin
                            phase_next = PH_ERROR;
                        end
                        else if (!zero_len)
                        begin
                            phase_next = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    if (body_end)
                    begin
                        phase_next = PH_PREFIX;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // datapath and results
    always_comb
    begin
        hpos_next = hpos_reg;
        len_next  = len_reg;
        left_next = left_reg;
        plen_next = plen_reg;
        ctx_next  = ctx_reg;
        done_next = done_reg;
        err_next  = err_reg;
        push      = '0;
        if (is_end)
        begin
            push.n              = 2'd1;
            push.r0.kind        = (verdict_err == ERR_NONE) ? KIND_ACCEPT : KIND_REJECT;
            push.r0.error_code  = verdict_err;
            push.r0.chunk_count = done_reg;
            push.r0.last        = 1'b1;
            hpos_next = '0;
            len_next  = '0;
            left_next = '0;
            plen_next = '0;
            ctx_next  = '0;
            done_next = '0;
            err_next  = ERR_NONE;
        end
        else if (is_data)
        begin
            case (phase_reg)
                PH_PREFIX:
                begin
                    hpos_next = HPOS_W'(hpos_reg + 1'b1);
                    len_next  = len_cur;
                    ctx_next  = ctx_cur;
                    if (hdr_end)
                    begin
                        if (short_len)
                        begin
                            err_next = ERR_LEN_SHORT;
                        end
                        else if (huge_len)
                        begin
                            err_next = ERR_LEN_EXCEEDS;
                        end
                        else if (zero_len)
                        begin
                            // empty payload closes the chunk right away
                            push.n              = 2'd1;
                            push.r0.kind        = KIND_CHUNK_END;
                            push.r0.chunk_index = done_reg;
                            push.r0.context_word = ctx_cur;
                            push.r0.last        = 1'b1;
                            done_next = done_reg + 32'd1;
                            hpos_next = '0;
                            len_next  = '0;
                            ctx_next  = '0;
                        end
                        else
                        begin
                            left_next = diff[31:0];
                            plen_next = diff[31:0];
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    push.r0.kind         = KIND_PAYLOAD;
                    push.r0.payload_byte = in_byte;
                    push.r0.chunk_index  = done_reg;
                    push.r0.context_word = ctx_reg;
                    left_next = left_reg - 32'd1;
                    if (body_end)
                    begin
                        push.n                 = 2'd2;
                        push.r1.kind           = KIND_CHUNK_END;
                        push.r1.chunk_index    = done_reg;
                        push.r1.payload_length = plen_reg;
                        push.r1.context_word   = ctx_reg;
                        push.r1.last           = 1'b1;
                        done_next = done_reg + 32'd1;
                        hpos_next = '0;
                        len_next  = '0;
                        ctx_next  = '0;
                    end
                    else
                    begin
                        push.n       = 2'd1;
                        push.r0.last = 1'b1;
                    end
                end
                default:
                begin
                    // bytes after an error are dropped
                    push = '0;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_PREFIX;
            hpos_reg  <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
            plen_reg  <= '0;
            ctx_reg   <= '0;
            done_reg  <= '0;
            err_reg   <= ERR_NONE;
        end
        else
        begin
            phase_reg <= phase_next;
            hpos_reg  <= hpos_next;
            len_reg   <= len_next;
            left_reg  <= left_next;
            plen_reg  <= plen_next;
            ctx_reg   <= ctx_next;
            done_reg  <= done_next;
            err_reg   <= err_next;
        end
    end

`ifndef ASSERT_OFF
    a_error_phase_latched: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_ERROR) |-> (err_reg != ERR_NONE))
        else $error("error phase without latched error");

    a_pair_is_byte_then_end: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n == 2'd2) |->
            (push.r0.kind == KIND_PAYLOAD && push.r1.kind == KIND_CHUNK_END
             && push.r1.last && !push.r0.last))
        else $error("two results must be last payload byte then chunk end");

    a_end_clears_state: assert property (@(posedge clk) disable iff (!rst_n)
        is_end |=> (phase_reg == PH_PREFIX && hpos_reg == '0 && done_reg == 32'd0))
        else $error("end of buffer did not return state to reset");
`endif

endmodule : lpcd_parser

`default_nettype wire

FILE: rtl/core/lpcd_result_queue.sv
// Four-entry result queue between the parser and the output stream.
// Depends on lpcd_pkg; takes up to two results per cycle, gives one when out_ready is high.
`timescale 1ns / 1ps
`default_nettype none

module lpcd_result_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  lpcd_pkg::push_t   push,
    input  logic              out_ready,
    output logic              out_valid,
    output lpcd_pkg::result_t head,
    output logic              room
);
    import lpcd_pkg::*;

    result_t           entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic [QPTR_W-1:0] wr_ptr_plus1;
    logic              pop;

    assign out_valid    = count_reg != '0;
    assign head         = entries_reg[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    // room for a worst-case pair of results
    assign room         = count_reg <= QCNT_W'(QUEUE_DEPTH - 2);
    assign wr_ptr_plus1 = QPTR_W'(wr_ptr_reg + 1'b1);

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = QPTR_W'(wr_ptr_reg + push.n);
        rd_ptr_next = QPTR_W'(rd_ptr_reg + pop);
        count_next  = QCNT_W'(count_reg + QCNT_W'(push.n) - QCNT_W'(pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            entries_reg[wr_ptr_reg] <= push.r0;
        end
        if (push.n == 2'd2)
        begin
            entries_reg[wr_ptr_plus1] <= push.r1;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n != 2'd0) |-> room)
        else $error("result pushed without room");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("result queue count beyond depth");

    a_pair_grows_by_two: assert property (@(posedge clk) disable iff (!rst_n)
        (push.n == 2'd2 && !pop) |=> (count_reg == QCNT_W'($past(count_reg) + 3'd2)))
        else $error("result pair not counted");
`endif

endmodule : lpcd_result_queue

`default_nettype wire

FILE: rtl/core/length_prefixed_chunk_deframer.sv
// Results are written into the result queue when the byte is accepted and offered on the master side from there.
// Throughput: one byte per cycle; a chunk's last payload byte yields two results but its
// header yields none, so with m_tready high the input never stalls; tready drops only
// while the result queue holds more than two entries.
// Reset: rst_n is asynchronous, active low; parser returns to the length prefix and the
// queue empties, no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module length_prefixed_chunk_deframer #(
    parameter int LENGTH_BYTES  = 8,
    parameter int CONTEXT_BYTES = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // in_byte
    input  logic [0:0]                      s_tuser,   // action
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // payload_byte, chunk_index, payload_length, context_word, error_code,
    // chunk_count, zero fill
    output logic [lpcd_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [1:0]                      m_tuser,   // kind
    output logic                            m_tlast
);
    import lpcd_pkg::*;

    push_t   push;
    result_t head;
    logic    room;
    logic    s_accept;

    // input transaction
    assign s_tready = room;
    assign s_accept = s_tvalid && s_tready;

    lpcd_parser #(
        .LENGTH_BYTES  (LENGTH_BYTES),
        .CONTEXT_BYTES (CONTEXT_BYTES)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_accept),
        .in_action (s_tuser[0]),
        .in_byte   (s_tdata),
        .push      (push)
    );

    lpcd_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .head      (head),
        .room      (room)
    );

    // output transaction packing
    assign m_tdata = {6'd0, head.chunk_count, head.error_code, head.context_word,
                      head.payload_length, head.chunk_index, head.payload_byte};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule : length_prefixed_chunk_deframer

`default_nettype wire

FILE: bench/length_prefixed_chunk_deframer_test.sv
// Self-checking bench for the length-prefixed chunk deframer: directed and random buffers,
// with a transaction-level predictor of the deframing state and a queue of expected results.
// Depends on lpcd_pkg and the length_prefixed_chunk_deframer top level.
`timescale 1ns / 1ps

module length_prefixed_chunk_deframer_test;

    import lpcd_pkg::*;

    localparam int LEN_BYTES       = 8;
    localparam int CTX_BYTES       = 4;
    localparam int GAP_LOW_PCT     = 11;
    localparam int GAP_HIGH_PCT    = 49;
    localparam int RANDOM_BYTES    = 1500;
    localparam int PRESSURE_AT     = 300;
    localparam int PRESSURE_CYCLES = 400;
    localparam int STALL_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 10;
    localparam int PRINT_LIMIT     = 50;

    typedef struct packed {
        logic       action;
        logic [7:0] data;
    } buf_byte_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata = '0;
    logic [0:0]            s_tuser = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;

    // stimulus and expected results
    buf_byte_t buf_bytes_q[$];
    buf_byte_t next_byte;
    result_t   frame_events_q[$];
    result_t   want;

    int total_bytes = 0;
    int bytes_accepted = 0;
    int results_seen = 0;
    int mismatch_count = 0;
    int stall_cycles = 0;
    int hold_left = 0;
    bit pressure_done = 1'b0;
    int send_gap_pct;
    int recv_gap_pct;

    // predictor state
    phase_t      dfr_phase = PH_PREFIX;
    int          hdr_pos = 0;
    logic [63:0] len_acc = '0;
    logic [31:0] body_left = '0;
    logic [31:0] ctx_reg = '0;
    logic [31:0] chunks_done = '0;
    err_t        err_latch = ERR_NONE;

    length_prefixed_chunk_deframer dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // idle rates per stage: sender light / receiver heavy, swapped, then none
    always_comb
    begin
        if (bytes_accepted * 3 < total_bytes)
        begin
            send_gap_pct = GAP_LOW_PCT;
            recv_gap_pct = GAP_HIGH_PCT;
        end
        else if (bytes_accepted * 3 < total_bytes * 2)
        begin
            send_gap_pct = GAP_HIGH_PCT;
            recv_gap_pct = GAP_LOW_PCT;
        end
        else
        begin
            send_gap_pct = 0;
            recv_gap_pct = 0;
        end
    end

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch on %s at result %0d: got %0h, expected %0h",
                     field, results_seen, got, exp_val);
        mismatch_count++;
    endtask

    task automatic clear_chunk();
        hdr_pos   = 0;
        len_acc   = '0;
        ctx_reg   = '0;
        body_left = '0;
        dfr_phase = PH_PREFIX;
    endtask

    // advance the deframing state by one accepted transaction, queue its results
    task automatic deframe_byte(input logic action, input logic [7:0] b);
        result_t     r;
        err_t        e;
        logic [63:0] plen;
        r = '0;
        if (action)
        begin
            // end of buffer: verdict, then back to the start state
            e = err_latch;
            if (e == ERR_NONE)
            begin
                if (dfr_phase == PH_PAYLOAD)
                    e = ERR_LEN_EXCEEDS;
                else if (hdr_pos != 0)
                    e = ERR_TRUNC_HEADER;
            end
            r.kind        = (e == ERR_NONE) ? KIND_ACCEPT : KIND_REJECT;
            r.error_code  = e;
            r.chunk_count = chunks_done;
            r.last        = 1'b1;
            frame_events_q.push_back(r);
            clear_chunk();
            chunks_done = '0;
            err_latch   = ERR_NONE;
        end
        else if (dfr_phase == PH_PREFIX)
        begin
            // length bytes then context bytes, little-endian
            if (hdr_pos < LEN_BYTES)
                len_acc[8*hdr_pos +: 8] = b;
            else
                ctx_reg[8*(hdr_pos-LEN_BYTES) +: 8] = b;
            hdr_pos++;
            if (hdr_pos == LEN_BYTES + CTX_BYTES)
            begin
                plen = len_acc - CTX_BYTES;
                if (len_acc < CTX_BYTES)
                begin
                    err_latch = ERR_LEN_SHORT;
                    dfr_phase = PH_ERROR;
                end
                else if (plen > 64'hFFFF_FFFF)
                begin
                    err_latch = ERR_LEN_EXCEEDS;
                    dfr_phase = PH_ERROR;
                end
                else if (plen == 0)
                begin
                    // empty payload closes the chunk right away
                    r.kind         = KIND_CHUNK_END;
                    r.chunk_index  = chunks_done;
                    r.context_word = ctx_reg;
                    r.last         = 1'b1;
                    frame_events_q.push_back(r);
                    chunks_done++;
                    clear_chunk();
                end
                else
                begin
                    body_left = plen[31:0];
                    dfr_phase = PH_PAYLOAD;
                end
            end
        end
        else if (dfr_phase == PH_PAYLOAD)
        begin
            r.kind         = KIND_PAYLOAD;
            r.payload_byte = b;
            r.chunk_index  = chunks_done;
            r.context_word = ctx_reg;
            body_left--;
            r.last         = (body_left != 0);
            frame_events_q.push_back(r);
            if (body_left == 0)
            begin
                r              = '0;
                r.kind         = KIND_CHUNK_END;
                r.chunk_index  = chunks_done;
                r.payload_length = len_acc[31:0] - CTX_BYTES;
                r.context_word = ctx_reg;
                r.last         = 1'b1;
                frame_events_q.push_back(r);
                chunks_done++;
                clear_chunk();
            end
        end
        // bytes after an error are dropped without a result
    endtask

    // sender: offers bytes from the stimulus queue with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                deframe_byte(s_tuser[0], s_tdata);
                bytes_accepted <= bytes_accepted + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (buf_bytes_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct)
                begin
                    next_byte = buf_bytes_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tuser  <= next_byte.action;
                    s_tdata  <= next_byte.data;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: checks each result transaction, random stalls plus one long hold
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (frame_events_q.size() == 0)
                    report_mismatch("unexpected result kind", m_tuser, 0);
                else
                begin
                    want = frame_events_q.pop_front();
                    if (m_tuser != want.kind)
                        report_mismatch("kind", m_tuser, want.kind);
                    if (m_tdata[7:0] != want.payload_byte)
                        report_mismatch("payload_byte", m_tdata[7:0], want.payload_byte);
                    if (m_tdata[39:8] != want.chunk_index)
                        report_mismatch("chunk_index", m_tdata[39:8], want.chunk_index);
                    if (m_tdata[71:40] != want.payload_length)
                        report_mismatch("payload_length", m_tdata[71:40],
                                        want.payload_length);
                    if (m_tdata[103:72] != want.context_word)
                        report_mismatch("context_word", m_tdata[103:72], want.context_word);
                    if (m_tdata[105:104] != want.error_code)
                        report_mismatch("error_code", m_tdata[105:104], want.error_code);
                    if (m_tdata[137:106] != want.chunk_count)
                        report_mismatch("chunk_count", m_tdata[137:106], want.chunk_count);
                    if (m_tlast != want.last)
                        report_mismatch("last", m_tlast, want.last);
                end
                results_seen <= results_seen + 1;
            end
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else if (!pressure_done && results_seen == PRESSURE_AT)
            begin
                // long hold so the result queue fills and the input stalls
                hold_left     <= PRESSURE_CYCLES;
                pressure_done <= 1'b1;
                m_tready      <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic add_byte(input logic [7:0] b);
        buf_bytes_q.push_back('{action: 1'b0, data: b});
    endtask

    task automatic add_end();
        buf_bytes_q.push_back('{action: 1'b1, data: 8'($urandom)});
    endtask

    task automatic add_header(input logic [63:0] len, input logic [31:0] ctx);
        for (int i = 0; i < LEN_BYTES; i++)
            add_byte(len[8*i +: 8]);
        for (int i = 0; i < CTX_BYTES; i++)
            add_byte(ctx[8*i +: 8]);
    endtask

    task automatic add_random_bytes(input int n);
        for (int i = 0; i < n; i++)
            add_byte(8'($urandom));
    endtask

    task automatic add_good_chunk();
        int plen;
        plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
        add_header(64'(plen) + CTX_BYTES, $urandom);
        add_random_bytes(plen);
    endtask

    initial
    begin
        int sel;
        int plen;
        int nsent;

        // empty buffer
        add_end();
        // two-byte payload with extreme bytes, then an empty-payload chunk
        add_header(64'd6, 32'h00FF_A55A);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_header(64'd4, 32'hFFFF_FFFF);
        add_end();
        // length below context, then a byte that is dropped
        add_header(64'd3, 32'h1234_5678);
        add_byte(8'hFF);
        add_end();
        // payload length too big for 32 bits
        add_header(64'h0000_0001_0000_0004, 32'h0);
        add_end();
        // buffer ends inside the length prefix
        add_random_bytes(5);
        add_end();
        // largest payload length, buffer ends inside the body
        add_header(64'h0000_0001_0000_0003, 32'hCAFE_0001);
        add_random_bytes(3);
        add_end();

        // random buffers: mostly well formed, some broken
        while (buf_bytes_q.size() < RANDOM_BYTES)
        begin
            sel = $urandom_range(0, 99);
            for (int c = $urandom_range(0, 4); c > 0; c--)
                add_good_chunk();
            if (sel < 72)
            begin
                // well formed
            end
            else if (sel < 80)
            begin
                add_header(64'($urandom_range(0, CTX_BYTES - 1)), $urandom);
                add_random_bytes($urandom_range(0, 3));
            end
            else if (sel < 85)
            begin
                add_header({32'($urandom_range(1, 32'hFFFF_FFFF)), 32'($urandom)}, $urandom);
                add_random_bytes($urandom_range(0, 3));
            end
            else if (sel < 92)
                add_random_bytes($urandom_range(1, LEN_BYTES + CTX_BYTES - 1));
            else
            begin
                plen = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 30)
                                                   : $urandom_range(1, 32'h7FFF_FFFF);
                nsent = (plen > 20) ? $urandom_range(0, 20) : $urandom_range(0, plen - 1);
                add_header(64'(plen) + CTX_BYTES, $urandom);
                add_random_bytes(nsent);
            end
            add_end();
        end
        total_bytes = buf_bytes_q.size();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // drain everything, then keep watching for stray results
        while (buf_bytes_q.size() != 0 || s_tvalid || frame_events_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0 && frame_events_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
